>>> src/assert_macros.svh
// assertion macros for the rtl of the step pulse generator, used by spg_core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every clock edge outside reset
`define SPG_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked on every clock edge outside reset
`define SPG_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/spg_pkg.sv
// types and constants of the step pulse generator
`default_nettype none

package spg_pkg;

   // opcodes of an input item
   localparam logic [2:0] OP_TICK      = 3'd0;
   localparam logic [2:0] OP_TURN      = 3'd1;
   localparam logic [2:0] OP_RUN       = 3'd2;
   localparam logic [2:0] OP_STOP      = 3'd3;
   localparam logic [2:0] OP_ENGAGE    = 3'd4;
   localparam logic [2:0] OP_DISENGAGE = 3'd5;
   localparam logic [2:0] OP_ZERO_POS  = 3'd6;

   // register indexes of the csr port
   localparam logic [0:0] CSR_STEP_DELAY    = 1'b0;
   localparam logic [0:0] CSR_STEPS_PER_REV = 1'b1;

   localparam logic [23:0] STEP_DELAY_RESET    = 24'd1250;
   localparam logic [15:0] STEPS_PER_REV_RESET = 16'd1600;

   // 360 degrees in q8 units; one step of a turn is worth this much product
   localparam logic [39:0] DEG_SCALE = 40'd92160;

   typedef struct packed {
      logic        valid;
      logic [2:0]  op;
      logic [23:0] degrees_q8;
      logic        forward;
   } cmd_type;

   typedef struct packed {
      logic [23:0] step_period;
      logic [15:0] rev_steps;
   } cfg_type;

   typedef struct packed {
      logic               step_line;
      logic               dir_line;
      logic               enable_n;
      logic               busy_res;
      logic signed [31:0] position;
   } rsp_type;

endpackage

`default_nettype wire

>>> src/spg_in_stage.sv
// input register with valid bit for command and tick items
`default_nettype none

module spg_in_stage (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire logic [2:0]      req_op,
   input  wire logic [23:0]     req_degrees_q8,
   input  wire logic            req_forward,
   input  wire logic            take,
   output spg_pkg::cmd_type     held
);

   logic        valid_ff;
   logic        valid_in;
   logic [2:0]  op_ff;
   logic [23:0] deg_ff;
   logic        fwd_ff;
   logic        load;

   // the register is free when empty or when its item moves on this cycle
   assign req_stall = valid_ff && !take;
   assign load      = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (load) begin
         op_ff  <= req_op;
         deg_ff <= req_degrees_q8;
         fwd_ff <= req_forward;
      end
   end

   assign held.valid      = valid_ff;
   assign held.op         = op_ff;
   assign held.degrees_q8 = deg_ff;
   assign held.forward    = fwd_ff;

endmodule

`default_nettype wire

>>> src/spg_core.sv
// motion state and step timing, updated once per item
`default_nettype none

`include "assert_macros.svh"

module spg_core #(
   parameter int PULSE_TICKS = 10
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire spg_pkg::cmd_type cmd,
   input  wire spg_pkg::cfg_type cfg,
   output spg_pkg::rsp_type      result
);

   localparam logic [23:0] PULSE_W = 24'(PULSE_TICKS);

   logic               engaged_ff, engaged_in;
   logic               running_ff, running_in;
   logic               endless_ff, endless_in;
   logic               heading_ff, heading_in;
   logic               halt_ff, halt_in;
   // remaining turn distance, kept as steps * DEG_SCALE plus the fraction
   logic [39:0]        turn_rem_ff, turn_rem_in;
   logic [23:0]        phase_ff, phase_in;
   logic signed [31:0] step_count_ff, step_count_in;

   logic [23:0]        phase_inc;
   logic [23:0]        eff_delay;
   logic [39:0]        turn_product;
   logic               has_step;

   // next state for the item in the input register
   always_comb begin
      engaged_in    = engaged_ff;
      running_in    = running_ff;
      endless_in    = endless_ff;
      heading_in    = heading_ff;
      halt_in       = halt_ff;
      turn_rem_in   = turn_rem_ff;
      phase_in      = phase_ff;
      step_count_in = step_count_ff;

      phase_inc    = phase_ff + 24'd1;
      eff_delay    = (cfg.step_period <= PULSE_W) ? PULSE_W + 24'd1 : cfg.step_period;
      turn_product = 40'(cmd.degrees_q8) * 40'(cfg.rev_steps);
      has_step     = turn_rem_ff >= spg_pkg::DEG_SCALE;

      if (cmd.valid) begin
         unique case (cmd.op) inside
            spg_pkg::OP_TICK: begin
               if (running_ff) begin
                  if (phase_ff == 24'd0 && (halt_ff || (!endless_ff && !has_step))) begin
                     // step boundary with nothing left to do
                     running_in = 1'b0;
                     halt_in    = 1'b0;
                     endless_in = 1'b0;
                  end else if (phase_inc >= eff_delay) begin
                     phase_in      = 24'd0;
                     step_count_in = heading_ff ? step_count_ff + 32'sd1
                                                : step_count_ff - 32'sd1;
                     if (!endless_ff && has_step) begin
                        turn_rem_in = turn_rem_ff - spg_pkg::DEG_SCALE;
                     end
                  end else begin
                     phase_in = phase_inc;
                  end
               end
            end
            spg_pkg::OP_TURN, spg_pkg::OP_RUN: begin
               if (engaged_ff && !running_ff) begin
                  halt_in     = 1'b0;
                  running_in  = 1'b1;
                  endless_in  = (cmd.op == spg_pkg::OP_RUN);
                  heading_in  = cmd.forward;
                  turn_rem_in = (cmd.op == spg_pkg::OP_RUN) ? 40'd0 : turn_product;
                  phase_in    = 24'd0;
               end
            end
            spg_pkg::OP_STOP: begin
               if (running_ff) begin
                  halt_in = 1'b1;
               end
            end
            spg_pkg::OP_ENGAGE: begin
               engaged_in = 1'b1;
            end
            spg_pkg::OP_DISENGAGE: begin
               engaged_in = 1'b0;
            end
            spg_pkg::OP_ZERO_POS: begin
               step_count_in = 32'sd0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         engaged_ff    <= 1'b0;
         running_ff    <= 1'b0;
         endless_ff    <= 1'b0;
         heading_ff    <= 1'b0;
         halt_ff       <= 1'b0;
         turn_rem_ff   <= 40'd0;
         phase_ff      <= 24'd0;
         step_count_ff <= 32'sd0;
      end else begin
         engaged_ff    <= engaged_in;
         running_ff    <= running_in;
         endless_ff    <= endless_in;
         heading_ff    <= heading_in;
         halt_ff       <= halt_in;
         turn_rem_ff   <= turn_rem_in;
         phase_ff      <= phase_in;
         step_count_ff <= step_count_in;
      end
   end

   // result shows the state after the item
   assign result.step_line = running_in && phase_in >= 24'd1 && phase_in <= PULSE_W;
   assign result.dir_line  = heading_in;
   assign result.enable_n  = !engaged_in;
   assign result.busy_res  = running_in;
   assign result.position  = step_count_in;

   `SPG_ASSERT_NOW(a_halt_only_running, !running_ff, !halt_ff, "stop pending while idle")
   `SPG_ASSERT_NOW(a_endless_only_running, endless_ff, running_ff, "endless flag while idle")
   `SPG_ASSERT_NEXT(a_idle_tick_holds_pos,
      cmd.valid && cmd.op == spg_pkg::OP_TICK && !running_ff,
      $stable(step_count_ff), "position moved on a tick while idle")

endmodule

`default_nettype wire

>>> src/stepper_step_pulse_generator.sv
// Step/direction pulse generator for a stepper driver.
// Request channel (req_*): one item per valid/stall handshake. op 0 is a
// 1 us tick from a timebase; ops 1..6 are turn, run continuous, stop,
// engage, disengage and zero position. degrees_q8 and forward feed turn/run.
// Response channel (rsp_*): exactly one item per request item, showing the
// step, direction and enable lines, busy flag and position after that item.
// Throughput: one item per cycle while rsp_stall is low; a single 24x16
// multiply for the turn distance sits between the input register and the
// result register, which drives rsp_valid.
// Stall: the result register, once full, holds while rsp_stall is high;
// the input register still takes one more item, then req_stall rises.
// csr port: write the step period (index 0) and the microsteps per
// revolution (index 1) only while the block holds no item.
// Reset (synchronous): driver disengaged, no move, position 0, period 1250,
// 1600 microsteps per revolution, both channel registers empty.
`default_nettype none

module stepper_step_pulse_generator #(
   parameter int PULSE_TICKS = 10
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [2:0]         req_op,
   input  wire logic [23:0]        req_degrees_q8,
   input  wire logic               req_forward,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_step_line,
   output logic                    rsp_dir_line,
   output logic                    rsp_enable_n,
   output logic                    rsp_busy_res,
   output logic signed [31:0]      rsp_position,
   input  wire logic               csr_wr_en,
   input  wire logic [0:0]         csr_index,
   input  wire logic [23:0]        csr_wdata
);

   spg_pkg::cmd_type held;
   spg_pkg::cmd_type cmd;
   spg_pkg::cfg_type cfg_ff;
   spg_pkg::rsp_type result;
   spg_pkg::rsp_type rsp_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             take;

   // held item moves on when the result register is free
   assign take = held.valid && (!rsp_valid_ff || !rsp_stall);

   spg_in_stage u_in_stage (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_degrees_q8 (req_degrees_q8),
      .req_forward    (req_forward),
      .take           (take),
      .held           (held)
   );

   always_comb begin
      cmd       = held;
      cmd.valid = take;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_period <= spg_pkg::STEP_DELAY_RESET;
         cfg_ff.rev_steps   <= spg_pkg::STEPS_PER_REV_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            spg_pkg::CSR_STEP_DELAY:    cfg_ff.step_period <= csr_wdata;
            spg_pkg::CSR_STEPS_PER_REV: cfg_ff.rev_steps   <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   spg_core #(
      .PULSE_TICKS (PULSE_TICKS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .cfg    (cfg_ff),
      .result (result)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_step_line = rsp_ff.step_line;
   assign rsp_dir_line  = rsp_ff.dir_line;
   assign rsp_enable_n  = rsp_ff.enable_n;
   assign rsp_busy_res  = rsp_ff.busy_res;
   assign rsp_position  = rsp_ff.position;

endmodule

`default_nettype wire
